[hdl/kse_pkg.sv]
// shared types, codes and key table for the keypad scan and entry block
package kse_pkg;

    // event codes carried on the result stream
    typedef enum logic [2:0] {
        EVT_NONE      = 3'd0,
        EVT_STORED    = 3'd1,
        EVT_ERASED    = 3'd2,
        EVT_ENTRY_OUT = 3'd3,
        EVT_EMPTY     = 3'd4,
        EVT_DROPPED   = 3'd5
    } evt_kind_t;

    localparam int unsigned BUF_SLOTS = 16;

    localparam logic [7:0] KEY_ENTER = 8'h45; // 'E'
    localparam logic [7:0] KEY_CLEAR = 8'h43; // 'C'

    localparam logic [3:0] DRIVE_ALL_LOW = 4'h0;
    localparam logic [3:0] COLS_RELEASED = 4'hF;

    // row by row: 123A 456B 789C E0FD
    localparam logic [7:0] KEY_TABLE [16] = '{
        8'h31, 8'h32, 8'h33, 8'h41,
        8'h34, 8'h35, 8'h36, 8'h42,
        8'h37, 8'h38, 8'h39, 8'h43,
        8'h45, 8'h30, 8'h46, 8'h44
    };

    // key handed over on release
    typedef struct packed {
        logic       valid;
        logic [7:0] key;
    } key_rel_t;

    // one result word, without the row drive
    typedef struct packed {
        evt_kind_t  kind;
        logic [7:0] ch;
        logic [3:0] pos;
        logic       last;
    } result_t;

endpackage

[hdl/kse_scan.sv]
// keypad row probe and release detection
module kse_scan
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick,
    input  logic [3:0]        cols,
    input  logic [7:0]        settle_ticks,
    output logic [3:0]        drive,
    output kse_pkg::key_rel_t key_rel
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PROBE,
        PH_RELEASE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  row_reg, row_next;
    logic [7:0]  settle_reg, settle_next;
    logic [7:0]  key_reg, key_next;
    logic [1:0]  col_low;
    logic [3:0]  probe_drive;

    // lowest low column, column 3 when only it is low
    always_comb
    begin
        if (!cols[0])
        begin
            col_low = 2'd0;
        end
        else if (!cols[1])
        begin
            col_low = 2'd1;
        end
        else if (!cols[2])
        begin
            col_low = 2'd2;
        end
        else
        begin
            col_low = 2'd3;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        row_next    = row_reg;
        settle_next = settle_reg;
        key_next    = key_reg;
        key_rel     = '0;
        unique case (phase_reg)
            PH_PROBE:
            begin
                if (settle_reg != 8'd0)
                begin
                    settle_next = settle_reg - 8'd1;
                end
                else if (cols != kse_pkg::COLS_RELEASED)
                begin
                    key_next   = kse_pkg::KEY_TABLE[{row_reg, col_low}];
                    phase_next = PH_RELEASE;
                end
                else if (row_reg == 2'd3)
                begin
                    phase_next = PH_IDLE;
                    row_next   = 2'd0;
                end
                else
                begin
                    row_next    = row_reg + 2'd1;
                    settle_next = settle_ticks;
                end
            end
            PH_RELEASE:
            begin
                if (cols == kse_pkg::COLS_RELEASED)
                begin
                    key_rel.valid = 1'b1;
                    key_rel.key   = key_reg;
                    phase_next    = PH_IDLE;
                    row_next      = 2'd0;
                end
            end
            default:
            begin
                if (cols != kse_pkg::COLS_RELEASED)
                begin
                    phase_next  = PH_PROBE;
                    row_next    = 2'd0;
                    settle_next = settle_ticks;
                end
            end
        endcase
    end

    // drive for the next tick follows from where the scan ends up
    assign probe_drive = ~(4'd1 << row_next);
    assign drive       = (phase_next == PH_IDLE) ? kse_pkg::DRIVE_ALL_LOW : probe_drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            row_reg    <= 2'd0;
            settle_reg <= 8'd0;
            key_reg    <= 8'd0;
        end
        else if (tick)
        begin
            phase_reg  <= phase_next;
            row_reg    <= row_next;
            settle_reg <= settle_next;
            key_reg    <= key_next;
        end
    end

endmodule

[hdl/kse_entry.sv]
// entry buffer with erase, store and ordered read-out on enter
module kse_entry #(
    parameter int unsigned ENTRY_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic               adv,
    input  kse_pkg::key_rel_t  key_rel,
    output kse_pkg::result_t   res,
    output logic               busy
);

    localparam int unsigned CAP   = (ENTRY_DEPTH < kse_pkg::BUF_SLOTS) ?
                                    ((ENTRY_DEPTH < 1) ? 1 : ENTRY_DEPTH) : kse_pkg::BUF_SLOTS;
    localparam int unsigned CNT_W = $clog2(CAP + 1);
    localparam int unsigned IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

    logic [7:0]       buf_mem [CAP];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             store_en;
    logic [CNT_W-1:0] count_dec;

    assign busy      = busy_reg;
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        res           = '0;
        res.kind      = kse_pkg::EVT_NONE;
        res.last      = 1'b1;
        count_next    = count_reg;
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        store_en      = 1'b0;
        if (busy_reg)
        begin
            // read-out of the remaining characters
            res.kind = kse_pkg::EVT_ENTRY_OUT;
            res.ch   = buf_mem[idx_reg];
            res.pos  = 4'(idx_reg);
            res.last = (idx_reg == last_idx_reg);
            if (adv)
            begin
                idx_next  = idx_reg + 1'b1;
                busy_next = (idx_reg != last_idx_reg);
            end
        end
        else if (key_rel.valid)
        begin
            if (key_rel.key == kse_pkg::KEY_ENTER)
            begin
                count_next = '0;
                if (count_reg == '0)
                begin
                    res.kind = kse_pkg::EVT_EMPTY;
                end
                else
                begin
                    // first character goes out now, the rest follow
                    res.kind      = kse_pkg::EVT_ENTRY_OUT;
                    res.ch        = buf_mem[0];
                    res.last      = (count_reg == CNT_W'(1));
                    busy_next     = (count_reg != CNT_W'(1));
                    idx_next      = IDX_W'(1);
                    last_idx_next = IDX_W'(count_dec);
                end
            end
            else if (key_rel.key == kse_pkg::KEY_CLEAR)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_dec;
                    res.kind   = kse_pkg::EVT_ERASED;
                    res.pos    = 4'(count_dec);
                end
            end
            else if (count_reg < CNT_W'(CAP))
            begin
                store_en   = 1'b1;
                count_next = count_reg + 1'b1;
                res.kind   = kse_pkg::EVT_STORED;
                res.ch     = key_rel.key;
                res.pos    = 4'(count_reg);
            end
            else
            begin
                res.kind = kse_pkg::EVT_DROPPED;
                res.ch   = key_rel.key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick && store_en)
        begin
            buf_mem[count_reg[IDX_W-1:0]] <= key_rel.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            last_idx_reg <= '0;
        end
        else if (tick || (busy_reg && adv))
        begin
            count_reg    <= count_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
        end
    end

endmodule

[hdl/keypad_scan_entry.sv]
// top level: 4x4 keypad scanner feeding a character entry buffer
// a result word passes through the input register, then the result register
// throughput: one input word per cycle unless a read-out or back-pressure holds it; an
// enter key with n stored characters gives n result words, one per cycle while
// m_axis_tready is high, and holds the input stage until the last of them is loaded
// reset: async active low; scan idle, buffer empty, settle_ticks back to 1
module keypad_scan_entry #(
    parameter int unsigned ENTRY_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // settle time register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // column samples
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] column_lines, [7:4] zero
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] row_drive, [11:4] entry_char,
                                        // [15:12] entry_position
    output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
    output logic        m_axis_tlast    // last_result
);

    logic              [7:0] settle_ticks_reg;

    // input register
    logic                    in_valid_reg;
    logic              [3:0] in_cols_reg;

    // result register
    logic                    out_valid_reg;
    logic              [3:0] out_drive_reg;
    kse_pkg::result_t        out_res_reg;

    logic                    load_ok;
    logic                    tick_fire;
    logic                    busy;
    logic              [3:0] scan_drive;
    kse_pkg::key_rel_t       key_rel;
    kse_pkg::result_t        res;

    // result register can take a word when empty or being drained
    assign load_ok   = !out_valid_reg || m_axis_tready;
    // a scan tick is processed only when no read-out is under way
    assign tick_fire = in_valid_reg && !busy && load_ok;
    assign s_axis_tready = !in_valid_reg || tick_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            settle_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cols_reg <= s_axis_tdata[3:0];
        end
    end

    kse_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick_fire),
        .cols         (in_cols_reg),
        .settle_ticks (settle_ticks_reg),
        .drive        (scan_drive),
        .key_rel      (key_rel)
    );

    // key_rel only counts on a processed tick
    kse_entry #(
        .ENTRY_DEPTH (ENTRY_DEPTH)
    ) u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_fire),
        .adv     (load_ok),
        .key_rel (key_rel),
        .res     (res),
        .busy    (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            out_valid_reg <= tick_fire || busy;
        end
    end

    // read-out words follow a release, which always leaves all rows low
    always_ff @(posedge clk)
    begin
        if (load_ok && (tick_fire || busy))
        begin
            out_drive_reg <= busy ? kse_pkg::DRIVE_ALL_LOW : scan_drive;
            out_res_reg   <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.pos, out_res_reg.ch, out_drive_reg};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last;

endmodule

[hdl/kse_checker.sv]
// port-level checks for the keypad scan and entry block
module kse_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // only read-out words may be followed by more words of the same tick
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tuser == kse_pkg::EVT_ENTRY_OUT && m_axis_tdata[3:0] == 4'h0)
        else $error("multi-word result that is not a read-out");

    // a no-event word carries no character or position
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == kse_pkg::EVT_NONE |-> m_axis_tdata[15:4] == 12'h0)
        else $error("no-event word with payload");

    // after a non-final read-out word the next accepted word continues the read-out
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser == kse_pkg::EVT_ENTRY_OUT
            && m_axis_tdata[15:12] == $past(m_axis_tdata[15:12]) + 4'd1)
        else $error("read-out sequence broken");

endmodule

bind keypad_scan_entry kse_checker u_kse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[test/keypad_scan_entry_checker.sv]
// result predictor and comparator for the keypad scan and entry block
module keypad_scan_entry_checker
#(
    parameter int unsigned ENTRY_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY = (ENTRY_DEPTH < 1) ? 1 :
                                       (ENTRY_DEPTH > kse_pkg::BUF_SLOTS) ?
                                       kse_pkg::BUF_SLOTS : ENTRY_DEPTH;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_PROBE,
        SCAN_RELEASE
    } scan_phase_t;

    typedef struct packed {
        logic [3:0]         rows;
        kse_pkg::evt_kind_t kind;
        logic [7:0]         ch;
        logic [3:0]         pos;
        logic               last;
    } key_word_t;

    key_word_t   expected_words [$];
    key_word_t   tick_words [$];

    logic [7:0]  settle_cfg;
    scan_phase_t phase;
    logic [1:0]  row;
    logic [7:0]  settle_left;
    logic [7:0]  held_key;
    logic [7:0]  entry_chars [kse_pkg::BUF_SLOTS];
    logic [4:0]  entry_cnt;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: keypad word mismatch on %s: got %0h, expected %0h",
                 $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_word(input kse_pkg::evt_kind_t kind, input logic [7:0] ch,
                            input logic [3:0] pos);
        key_word_t w;
        w.rows = kse_pkg::DRIVE_ALL_LOW;
        w.kind = kind;
        w.ch   = ch;
        w.pos  = pos;
        w.last = 1'b0;
        tick_words.push_back(w);
    endtask

    // entry buffer action for a released key
    task automatic enter_key(input logic [7:0] key);
        int i;
        if (key == kse_pkg::KEY_ENTER)
        begin
            if (entry_cnt == 0)
                add_word(kse_pkg::EVT_EMPTY, 8'h00, 4'h0);
            else
                for (i = 0; i < int'(entry_cnt); i++)
                    add_word(kse_pkg::EVT_ENTRY_OUT, entry_chars[i], i[3:0]);
            entry_cnt = '0;
        end
        else if (key == kse_pkg::KEY_CLEAR)
        begin
            if (entry_cnt != 0)
            begin
                entry_cnt--;
                add_word(kse_pkg::EVT_ERASED, 8'h00, entry_cnt[3:0]);
            end
            else
                add_word(kse_pkg::EVT_NONE, 8'h00, 4'h0);
        end
        else if (entry_cnt < CAPACITY)
        begin
            entry_chars[entry_cnt[3:0]] = key;
            add_word(kse_pkg::EVT_STORED, key, entry_cnt[3:0]);
            entry_cnt++;
        end
        else
            add_word(kse_pkg::EVT_DROPPED, key, 4'h0);
    endtask

    // one scan tick: advance the scanner and queue the words it gives
    task automatic scan_tick(input logic [3:0] cols);
        logic [3:0] rows;
        logic [1:0] low_col;
        key_word_t  w;
        int         i;
        rows = kse_pkg::DRIVE_ALL_LOW;
        tick_words.delete();
        case (phase)
            SCAN_PROBE:
            begin
                if (settle_left != 0)
                begin
                    settle_left--;
                    rows = 4'hF ^ (4'h1 << row);
                end
                else if (cols != kse_pkg::COLS_RELEASED)
                begin
                    low_col = 2'd3;
                    for (i = 2; i >= 0; i--)
                        if (!cols[i])
                            low_col = i[1:0];
                    held_key = kse_pkg::KEY_TABLE[{row, low_col}];
                    phase    = SCAN_RELEASE;
                    rows     = 4'hF ^ (4'h1 << row);
                end
                else if (row == 2'd3)
                begin
                    phase = SCAN_IDLE;
                    row   = 2'd0;
                end
                else
                begin
                    row++;
                    settle_left = settle_cfg;
                    rows        = 4'hF ^ (4'h1 << row);
                end
            end
            SCAN_RELEASE:
            begin
                if (cols == kse_pkg::COLS_RELEASED)
                begin
                    enter_key(held_key);
                    phase = SCAN_IDLE;
                    row   = 2'd0;
                end
                else
                    rows = 4'hF ^ (4'h1 << row);
            end
            default:
            begin
                if (cols != kse_pkg::COLS_RELEASED)
                begin
                    phase       = SCAN_PROBE;
                    row         = 2'd0;
                    settle_left = settle_cfg;
                    rows        = 4'hE;
                end
            end
        endcase
        if (tick_words.size() == 0)
            add_word(kse_pkg::EVT_NONE, 8'h00, 4'h0);
        for (i = 0; i < tick_words.size(); i++)
        begin
            w      = tick_words[i];
            w.rows = rows;
            w.last = (i == tick_words.size() - 1);
            expected_words.push_back(w);
        end
    endtask

    task automatic check_word();
        key_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("unexpected word", m_axis_tdata, 16'h0);
            return;
        end
        want = expected_words.pop_front();
        if (m_axis_tdata[3:0] !== want.rows)
            report_mismatch("row_drive", 16'(m_axis_tdata[3:0]), 16'(want.rows));
        if (m_axis_tuser !== want.kind)
            report_mismatch("event_kind", 16'(m_axis_tuser), 16'(want.kind));
        if (m_axis_tdata[11:4] !== want.ch)
            report_mismatch("entry_char", 16'(m_axis_tdata[11:4]), 16'(want.ch));
        if (m_axis_tdata[15:12] !== want.pos)
            report_mismatch("entry_position", 16'(m_axis_tdata[15:12]), 16'(want.pos));
        if (m_axis_tlast !== want.last)
            report_mismatch("last_result", 16'(m_axis_tlast), 16'(want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatches  = 0;
            settle_cfg  = 8'd1;
            phase       = SCAN_IDLE;
            row         = 2'd0;
            settle_left = 8'd0;
            held_key    = 8'd0;
            entry_cnt   = '0;
            expected_words.delete();
            words_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                settle_cfg = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (s_axis_tvalid && s_axis_tready)
                scan_tick(s_axis_tdata[3:0]);
            words_pending <= expected_words.size();
        end
    end

endmodule

[test/keypad_scan_entry_tb.sv]
// top of the keypad scan and entry testbench: clock, reset, stimulus and verdict
module keypad_scan_entry_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [7:0]  cfg_wr_data    = 8'h00;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata   = 8'h00;   // [3:0] column_lines, [7:4] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;             // [3:0] row_drive, [11:4] entry_char,
                                           // [15:12] entry_position
    logic [2:0]  m_axis_tuser;             // [2:0] event_kind
    logic        m_axis_tlast;             // last_result

    int mismatch_count;
    int words_pending;

    // stimulus bookkeeping
    int       burst_left  = 0;
    int       items_sent  = 0;
    logic [7:0] settle    = 8'd1;          // our copy of the settle register
    bit       rx_hold_req = 1'b0;          // asks the receiver for one long hold-off

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    keypad_scan_entry dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    keypad_scan_entry_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatch_count),
        .words_pending (words_pending)
    );

    // offer one column word; the sender runs in bursts with random gaps between them
    task automatic send_cols(input logic [3:0] cols);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            // a quarter of the bursts follow on with no gap at all
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, cols};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (words_pending != 0);
        // two-stage pipe, plus margin
        repeat (4) @(posedge clk);
    endtask

    // settle register is only written with the block idle and nothing in flight
    task automatic set_settle(input logic [7:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        settle = value;
    endtask

    // settle ticks: column samples here are ignored, so anything goes
    task automatic settle_wait();
        repeat (settle) send_cols(4'($urandom_range(0, 15)));
    endtask

    // full press of the key at (r, c): start probe, step rows, hit, bounce, release
    task automatic press_key(input int r, input int c, input int bounce);
        logic [3:0] hit;
        logic [3:0] below;
        int i;
        send_cols(4'($urandom_range(0, 14)));           // any low column starts a probe
        settle_wait();
        for (i = 0; i < r; i++)
        begin
            send_cols(kse_pkg::COLS_RELEASED);          // no hit on this row, move on
            settle_wait();
        end
        // lowest low column is c; columns above c are random
        below = 4'((1 << c) - 1);
        hit   = (4'($urandom_range(0, 15)) & ~(below | (4'h1 << c))) | below;
        send_cols(hit);
        repeat (bounce) send_cols(4'($urandom_range(0, 14)));   // still held
        send_cols(kse_pkg::COLS_RELEASED);              // release hands the key over
    endtask

    task automatic press_char(input logic [7:0] ch, input int bounce);
        int idx;
        for (idx = 0; idx < 16; idx++)
            if (kse_pkg::KEY_TABLE[idx] == ch)
            begin
                press_key(idx / 4, idx % 4, bounce);
                break;
            end
    endtask

    // probe that finds no row: every sample after settling reads all high
    task automatic ghost_probe();
        int i;
        send_cols(4'($urandom_range(0, 14)));
        settle_wait();
        for (i = 0; i < 4; i++)
        begin
            send_cols(kse_pkg::COLS_RELEASED);
            if (i < 3)
                settle_wait();
        end
    endtask

    // table index of a random key other than enter or clear
    function automatic int plain_key_idx(input int n);
        int idx;
        idx = n % 14;
        if (idx >= 11)
            idx += 2;
        return idx;
    endfunction

    // receiver: changes stall pattern every so often, plus one long hold-off on request
    initial
    begin
        int rx_mode;
        int mode_left;
        rx_mode   = 0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;                          // no stalls
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));      // coin flip
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);   // rare stalls
                endcase
            end
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int p;
        int i;
        int act;
        int k;
        int phase_end;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, settle at its reset value of 1
        press_char(kse_pkg::KEY_ENTER, 0); // enter with nothing stored
        press_char(kse_pkg::KEY_CLEAR, 1); // clear with nothing stored
        ghost_probe();
        press_char(8'h31, 0);              // '1': row 0, column 0
        press_char(8'h44, 2);              // 'D': row 3, column 3
        press_char(kse_pkg::KEY_CLEAR, 0); // erase 'D'
        press_char(kse_pkg::KEY_ENTER, 0); // one character out

        // no settling: fill the buffer, overflow once, then emit all sixteen
        set_settle(8'd0);
        for (i = 0; i < 17; i++)
            press_key(plain_key_idx(i) / 4, plain_key_idx(i) % 4, 0);
        press_char(kse_pkg::KEY_ENTER, 0);

        // longest settle on one row-0 key
        set_settle(8'd255);
        press_char(8'h41, 0);              // 'A': row 0, column 3

        // deep rows and a probe that runs through all rows
        set_settle(8'd3);
        press_char(8'h46, 1);              // 'F': row 3
        ghost_probe();
        press_char(kse_pkg::KEY_ENTER, 0);

        // random phases, each under its own settle value
        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:       set_settle(8'd2);
                1:       set_settle(8'd0);
                2:       set_settle(8'($urandom_range(0, 7)));
                3:       set_settle(8'd4);
                default: set_settle(8'd1);
            endcase

            // long hold-off on the result side while presses keep coming in
            if (p == 1)
            begin
                rx_hold_req = 1'b1;
                for (i = 0; i < 6; i++)
                    press_key($urandom_range(0, 3), $urandom_range(0, 3), 2);
            end

            phase_end = items_sent + 20;
            while (items_sent < phase_end)
            begin
                act = $urandom_range(0, 99);
                if (act < 75)
                begin
                    k = $urandom_range(0, 99);
                    if (k < 7)
                        press_char(kse_pkg::KEY_ENTER, $urandom_range(0, 3));
                    else if (k < 15)
                        press_char(kse_pkg::KEY_CLEAR, $urandom_range(0, 3));
                    else
                    begin
                        k = plain_key_idx($urandom_range(0, 13));
                        press_key(k / 4, k % 4, $urandom_range(0, 3));
                    end
                end
                else if (act < 85)
                    ghost_probe();
                else if (act < 93)
                    send_cols(kse_pkg::COLS_RELEASED);  // idle tick, nothing pressed
                else
                    press_key($urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(4, 8));     // long bounce before release

                // now and then let everything come back before going on
                if ($urandom_range(0, 49) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
